@@ hw/rtl/rrt_pkg.sv @@
// Types and constants shared by the rewrite-rule tokenizer modules.
`timescale 1ns / 1ps
`default_nettype none
package rrt_pkg;

   localparam logic [2:0] KIND_LEFT     = 3'd0;
   localparam logic [2:0] KIND_RIGHT    = 3'd1;
   localparam logic [2:0] KIND_END_LEFT = 3'd2;
   localparam logic [2:0] KIND_END_RULE = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   localparam logic [1:0] PHASE_ARROW = 2'd0;
   localparam logic [1:0] PHASE_LEFT  = 2'd1;
   localparam logic [1:0] PHASE_RIGHT = 2'd2;

   localparam logic [2:0] ARROW_NONE   = 3'd0;
   localparam logic [2:0] ARROW_DASH   = 3'd1;
   localparam logic [2:0] ARROW_EQUAL  = 3'd2;
   localparam logic [2:0] ARROW_NORMAL = 3'd3;
   localparam logic [2:0] ARROW_TERM   = 3'd4;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef struct packed {
      logic [1:0] rule_phase;
      logic [2:0] arrow_progress;
      logic       escape_pending;
      logic       inside_brackets;
      logic       after_space;
   } tok_state_type;

   typedef struct packed {
      logic [2:0] entry_kind;
      logic [7:0] char_out;
      logic       terminal_rule;
      logic       text_done;
      logic       last_of_item;
   } tok_result_type;

   localparam tok_state_type STATE_RESET = '0;

endpackage
`default_nettype wire

@@ hw/rtl/rrt_step.sv @@
// Per-character decode: next tokenizer state and up to two result beats.
`timescale 1ns / 1ps
`default_nettype none
module rrt_step (
   input  wire logic [7:0]             char_in,
   input  rrt_pkg::tok_state_type      cur_state,
   output rrt_pkg::tok_state_type      nxt_state,
   output logic [1:0]                  res_count,
   output rrt_pkg::tok_result_type     res0,
   output rrt_pkg::tok_result_type     res1
);
   import rrt_pkg::*;

   logic           err;
   logic           flush;
   logic           main_v;
   tok_result_type main_r;
   tok_result_type flush_r;
   logic [2:0]     side;

   always_comb begin
      nxt_state = cur_state;
      err       = 1'b0;
      flush     = 1'b0;
      main_v    = 1'b0;
      side      = (cur_state.rule_phase == PHASE_LEFT) ? KIND_LEFT : KIND_RIGHT;
      main_r    = '{entry_kind: side, char_out: char_in, terminal_rule: 1'b0,
                    text_done: 1'b0, last_of_item: 1'b1};
      flush_r   = '{entry_kind: side, char_out: CH_BSLASH, terminal_rule: 1'b0,
                    text_done: 1'b0, last_of_item: 1'b0};

      case (char_in)
         CH_BSLASH: begin
            if (cur_state.rule_phase == PHASE_ARROW) begin
               err = 1'b1;
            end else if (cur_state.escape_pending) begin
               nxt_state.escape_pending = 1'b0;
               main_v = 1'b1;
            end else begin
               nxt_state.escape_pending = 1'b1;
            end
            nxt_state.after_space = 1'b0;
         end
         CH_DASH, CH_EQUAL: begin
            if (cur_state.rule_phase == PHASE_ARROW) begin
               if (cur_state.arrow_progress != ARROW_NONE) err = 1'b1;
               else nxt_state.arrow_progress = (char_in == CH_DASH) ? ARROW_DASH
                                                                     : ARROW_EQUAL;
            end else begin
               flush = cur_state.escape_pending;
               nxt_state.escape_pending = 1'b0;
               main_v = 1'b1;
            end
            nxt_state.after_space = 1'b0;
         end
         CH_GT: begin
            if (cur_state.rule_phase == PHASE_ARROW) begin
               if (cur_state.arrow_progress == ARROW_NONE) err = 1'b1;
               else if (cur_state.arrow_progress == ARROW_DASH)
                  nxt_state.arrow_progress = ARROW_NORMAL;
               else if (cur_state.arrow_progress == ARROW_EQUAL)
                  nxt_state.arrow_progress = ARROW_TERM;
            end
            nxt_state.after_space = 1'b0;
         end
         CH_LBRACK, CH_RBRACK: begin
            if (cur_state.escape_pending) begin
               nxt_state.escape_pending = 1'b0;
               main_v = 1'b1;
            end else if (cur_state.rule_phase == PHASE_ARROW) begin
               err = 1'b1;
            end else if (char_in == CH_LBRACK) begin
               if (cur_state.inside_brackets) err = 1'b1;
               else nxt_state.inside_brackets = 1'b1;
            end else begin
               if (!cur_state.inside_brackets) err = 1'b1;
               else nxt_state.inside_brackets = 1'b0;
            end
            nxt_state.after_space = 1'b0;
         end
         CH_SPACE: begin
            if (cur_state.rule_phase == PHASE_ARROW) begin
               if (cur_state.arrow_progress >= ARROW_NORMAL)
                  nxt_state.rule_phase = PHASE_LEFT;
               else if (cur_state.arrow_progress != ARROW_NONE)
                  err = 1'b1;
            end else begin
               flush = cur_state.escape_pending;
               nxt_state.escape_pending = 1'b0;
               if (cur_state.inside_brackets) begin
                  main_v = 1'b1;
               end else if (!cur_state.after_space) begin
                  main_v = 1'b1;
                  main_r.char_out = '0;
                  if (cur_state.rule_phase == PHASE_LEFT) begin
                     main_r.entry_kind = KIND_END_LEFT;
                     nxt_state.rule_phase = PHASE_RIGHT;
                  end else begin
                     main_r.entry_kind = KIND_END_RULE;
                     main_r.terminal_rule = (cur_state.arrow_progress == ARROW_TERM);
                     nxt_state.rule_phase = PHASE_ARROW;
                     nxt_state.arrow_progress = ARROW_NONE;
                  end
               end
            end
            nxt_state.after_space = 1'b1;
         end
         CH_NUL: begin
            if (cur_state.rule_phase == PHASE_RIGHT && !cur_state.inside_brackets &&
                !cur_state.escape_pending) begin
               main_v = 1'b1;
               main_r.entry_kind = KIND_END_RULE;
               main_r.char_out = '0;
               main_r.terminal_rule = (cur_state.arrow_progress == ARROW_TERM);
               main_r.text_done = 1'b1;
            end else begin
               err = 1'b1;
            end
            nxt_state = STATE_RESET;
         end
         default: begin
            if (cur_state.rule_phase == PHASE_ARROW) begin
               err = 1'b1;
            end else begin
               flush = cur_state.escape_pending;
               nxt_state.escape_pending = 1'b0;
               main_v = 1'b1;
            end
            nxt_state.after_space = 1'b0;
         end
      endcase

      if (err) begin
         flush  = 1'b0;
         main_v = 1'b1;
         main_r = '{entry_kind: KIND_ERROR, char_out: 8'h00, terminal_rule: 1'b0,
                    text_done: 1'b0, last_of_item: 1'b1};
         nxt_state = STATE_RESET;
      end

      // flush is only ever set together with main_v
      res_count = {1'b0, flush} + {1'b0, main_v};
      res0      = flush ? flush_r : main_r;
      res1      = main_r;
   end

endmodule
`default_nettype wire

@@ hw/rtl/rrt_outq.sv @@
// Result register with one extra slot for the second beat of a character.
`timescale 1ns / 1ps
`default_nettype none
module rrt_outq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire logic [1:0]          res_count,
   input  rrt_pkg::tok_result_type  res0,
   input  rrt_pkg::tok_result_type  res1,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output rrt_pkg::tok_result_type  rsp_data,
   output logic                     can_push
);
   import rrt_pkg::*;

   logic           out_valid_ff, out_valid_in;
   tok_result_type out_data_ff, out_data_in;
   logic           pend_valid_ff, pend_valid_in;
   tok_result_type pend_data_ff, pend_data_in;
   logic           take;

   assign take     = out_valid_ff & rsp_ready;
   assign can_push = ~pend_valid_ff & (~out_valid_ff | rsp_ready);

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      if (push) begin
         out_valid_in  = (res_count != 2'd0);
         out_data_in   = res0;
         pend_valid_in = (res_count == 2'd2);
         pend_data_in  = res1;
      end else if (take) begin
         out_valid_in  = pend_valid_ff;
         out_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      out_data_ff  <= out_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/rewrite_rule_tokenizer_top.sv @@
// Rewrite-rule tokenizer: one text byte per beat in, pattern tokens out.
// The first result beat of a character is registered and is on rsp_ in the cycle after acceptance.
// Throughput: one character per cycle unless rsp_ready stalls the output; a character giving
// two results holds req_ready low until its second beat has left the extra result slot.
// Reset (synchronous, active high) clears the tokenizer state and both result slots.
`timescale 1ns / 1ps
`default_nettype none
module rewrite_rule_tokenizer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_entry_kind,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_terminal_rule,
   output logic            rsp_text_done,
   output logic            rsp_last_of_item
);
   import rrt_pkg::*;

   tok_state_type  state_ff, state_in;
   logic [1:0]     res_count;
   tok_result_type res0, res1, rsp_data;
   logic           can_push;
   logic           push;

   assign req_ready = can_push;
   assign push      = req_valid & can_push;

   rrt_step u_step (
      .char_in   (req_char_in),
      .cur_state (state_ff),
      .nxt_state (state_in),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (push) begin
         state_ff <= state_in;
      end
   end

   rrt_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .can_push  (can_push)
   );

   assign rsp_entry_kind    = rsp_data.entry_kind;
   assign rsp_char_out      = rsp_data.char_out;
   assign rsp_terminal_rule = rsp_data.terminal_rule;
   assign rsp_text_done     = rsp_data.text_done;
   assign rsp_last_of_item  = rsp_data.last_of_item;

endmodule
`default_nettype wire

@@ hw/rtl/rrt_checker.sv @@
// Port-level checks for the rewrite-rule tokenizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rrt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_entry_kind,
   input wire logic [7:0] rsp_char_out,
   input wire logic       rsp_terminal_rule,
   input wire logic       rsp_text_done,
   input wire logic       rsp_last_of_item
);
   import rrt_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_kind) &&
      $stable(rsp_char_out) && $stable(rsp_terminal_rule) && $stable(rsp_text_done) &&
      $stable(rsp_last_of_item))
      else $error("rsp beat changed while stalled");

   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_kind == KIND_ERROR |-> rsp_last_of_item &&
      rsp_char_out == 8'h00)
      else $error("error beat not alone");

   a_marker_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_kind == KIND_END_LEFT || rsp_entry_kind == KIND_END_RULE)
      |-> rsp_char_out == 8'h00 && rsp_last_of_item)
      else $error("marker beat carries a char or is not last");

   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_done |-> rsp_entry_kind == KIND_END_RULE)
      else $error("text_done on a non end-of-rule beat");

   // a non-last beat is always followed by the rest of the same character
   a_first_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_item |-> !req_ready)
      else $error("input taken while a second beat is pending");

endmodule

bind rewrite_rule_tokenizer_top rrt_checker u_rrt_checker (.*);
`default_nettype wire
